// ===== rtl/rcd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcd_pkg: shared types and constants of the RC command packet deframer
// Opcodes, register indexes, reset values and the structs passed between
// the configuration block, the frame engine and the top level.
// ----------------------------------------------------------------------------
package rcd_pkg;

   // Frame geometry: start byte excluded, last byte is the checksum
   localparam int FRAME_BYTES  = 10;
   localparam int STORED_BYTES = FRAME_BYTES - 1;
   localparam int COUNT_W      = $clog2(FRAME_BYTES);
   localparam logic [COUNT_W-1:0] LAST_BYTE = COUNT_W'(FRAME_BYTES - 1);

   // Item opcodes
   typedef enum logic [1:0] {
      OP_RX_BYTE = 2'd0,
      OP_TICK    = 2'd1,
      OP_CHECK   = 2'd2
   } rcd_opcode_type;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_MARKER   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_MS     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_THROTTLE_FLOOR = 2'd2;
   localparam int CSR_DATA_W = 16;

   // Reset values
   localparam logic [7:0]  START_MARKER_RST   = 8'd170;
   localparam logic [15:0] TIMEOUT_MS_RST     = 16'd500;
   localparam logic [15:0] THROTTLE_FLOOR_RST = 16'd1000;

   typedef struct packed {
      logic [7:0]  start_marker;
      logic [15:0] timeout_ms;
      logic [15:0] throttle_floor;
   } rcd_cfg_type;

   typedef struct packed {
      logic [15:0]        throttle;
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
      logic signed [15:0] yaw;
      logic [7:0]         armed;
      logic               packet_accepted;
      logic               checksum_bad;
      logic               link_safe;
   } rcd_result_type;

endpackage

// ===== rtl/rcd_req_if.sv =====
// ----------------------------------------------------------------------------
// rcd_req_if: input item channel of the deframer
// Valid/ready channel carrying one opcode and one received byte per item.
// ----------------------------------------------------------------------------
interface rcd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] rx_byte;

   modport source (output valid, output opcode, output rx_byte, input ready);
   modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

// ===== rtl/rcd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rcd_rsp_if: result item channel of the deframer
// Valid/ready channel carrying the latched commands and per-item flags.
// ----------------------------------------------------------------------------
interface rcd_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        throttle;
   logic signed [15:0] roll;
   logic signed [15:0] pitch;
   logic signed [15:0] yaw;
   logic [7:0]         armed;
   logic               packet_accepted;
   logic               checksum_bad;
   logic               link_safe;

   modport source (output valid, output throttle, output roll, output pitch,
                   output yaw, output armed, output packet_accepted,
                   output checksum_bad, output link_safe, input ready);
   modport sink   (input valid, input throttle, input roll, input pitch,
                   input yaw, input armed, input packet_accepted,
                   input checksum_bad, input link_safe, output ready);
endinterface

// ===== rtl/rcd_csr.sv =====
// ----------------------------------------------------------------------------
// rcd_csr: configuration registers of the deframer
// Holds start marker, link timeout and failsafe throttle; write only.
// ----------------------------------------------------------------------------
module rcd_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [rcd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rcd_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output rcd_pkg::rcd_cfg_type         cfg
);
   import rcd_pkg::*;

   rcd_cfg_type cfg_ff;
   rcd_cfg_type cfg_in;

   // Decode the write; unknown indexes leave everything untouched
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_START_MARKER:   cfg_in.start_marker   = csr_wr_data[7:0];
            CSR_TIMEOUT_MS:     cfg_in.timeout_ms     = csr_wr_data;
            CSR_THROTTLE_FLOOR: cfg_in.throttle_floor = csr_wr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker   <= START_MARKER_RST;
         cfg_ff.timeout_ms     <= TIMEOUT_MS_RST;
         cfg_ff.throttle_floor <= THROTTLE_FLOOR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/rcd_engine.sv =====
// ----------------------------------------------------------------------------
// rcd_engine: frame collection, checksum, command latches and link timer
// Applies one item per step and presents the result it causes.
// ----------------------------------------------------------------------------
module rcd_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [1:0]              opcode,
   input  logic [7:0]              rx_byte,
   input  rcd_pkg::rcd_cfg_type    cfg,
   output rcd_pkg::rcd_result_type result
);
   import rcd_pkg::*;

   logic                     collecting_ff, collecting_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [7:0]               sum_ff, sum_in;
   logic [7:0]               bytes_ff [STORED_BYTES];
   logic                     store_byte;
   logic [31:0]              now_ff, now_in;
   logic [31:0]              last_good_ff, last_good_in;
   logic [31:0]              elapsed;
   logic [15:0]              throttle_ff, throttle_in;
   logic signed [15:0]       roll_ff, roll_in;
   logic signed [15:0]       pitch_ff, pitch_in;
   logic signed [15:0]       yaw_ff, yaw_in;
   logic [7:0]               armed_ff, armed_in;
   logic                     accepted, bad, safe;

   assign elapsed = now_ff - last_good_ff;

   // Work out the next state for the current item
   always_comb begin
      collecting_in = collecting_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      store_byte    = 1'b0;
      now_in        = now_ff;
      last_good_in  = last_good_ff;
      throttle_in   = throttle_ff;
      roll_in       = roll_ff;
      pitch_in      = pitch_ff;
      yaw_in        = yaw_ff;
      armed_in      = armed_ff;
      accepted      = 1'b0;
      bad           = 1'b0;
      safe          = 1'b0;
      unique case (opcode)
         OP_RX_BYTE: begin
            if (!collecting_ff) begin
               // hunt for the start byte
               if (rx_byte == cfg.start_marker) begin
                  collecting_in = 1'b1;
                  count_in      = '0;
                  sum_in        = '0;
               end
            end else if (count_ff == LAST_BYTE) begin
               // checksum byte closes the frame
               collecting_in = 1'b0;
               count_in      = '0;
               if (sum_ff == rx_byte) begin
                  accepted     = 1'b1;
                  throttle_in  = {bytes_ff[0], bytes_ff[1]};
                  roll_in      = $signed({bytes_ff[2], bytes_ff[3]});
                  pitch_in     = $signed({bytes_ff[4], bytes_ff[5]});
                  yaw_in       = $signed({bytes_ff[6], bytes_ff[7]});
                  armed_in     = bytes_ff[8];
                  last_good_in = now_ff;
               end else begin
                  bad = 1'b1;
               end
            end else begin
               // store payload byte and add it to the running sum
               store_byte = 1'b1;
               sum_in     = sum_ff + rx_byte;
               count_in   = count_ff + COUNT_W'(1);
            end
         end
         OP_TICK: begin
            now_in = now_ff + 32'd1;
         end
         OP_CHECK: begin
            // failsafe once the link has been quiet too long
            if (elapsed > {16'd0, cfg.timeout_ms}) begin
               throttle_in = cfg.throttle_floor;
               armed_in    = '0;
            end else begin
               safe = 1'b1;
            end
         end
         default: begin
            safe = 1'b0;
         end
      endcase
   end

   // Control and command state
   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         count_ff      <= '0;
         sum_ff        <= '0;
         now_ff        <= '0;
         last_good_ff  <= '0;
         throttle_ff   <= THROTTLE_FLOOR_RST;
         roll_ff       <= '0;
         pitch_ff      <= '0;
         yaw_ff        <= '0;
         armed_ff      <= '0;
      end else if (step) begin
         collecting_ff <= collecting_in;
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         now_ff        <= now_in;
         last_good_ff  <= last_good_in;
         throttle_ff   <= throttle_in;
         roll_ff       <= roll_in;
         pitch_ff      <= pitch_in;
         yaw_ff        <= yaw_in;
         armed_ff      <= armed_in;
      end
   end

   // Frame byte store, written only while collecting
   always_ff @(posedge clock) begin
      if (step && store_byte) begin
         bytes_ff[count_ff] <= rx_byte;
      end
   end

   // Result reflects the state after this item
   always_comb begin
      result.throttle        = throttle_in;
      result.roll            = roll_in;
      result.pitch           = pitch_in;
      result.yaw             = yaw_in;
      result.armed           = armed_in;
      result.packet_accepted = accepted;
      result.checksum_bad    = bad;
      result.link_safe       = safe;
   end

endmodule

// ===== rtl/rc_command_packet_deframer_core.sv =====
// ----------------------------------------------------------------------------
// rc_command_packet_deframer_core: RC command packet deframer, top level
// Input register, frame engine and result register around a valid/ready
// item stream, plus a write-only configuration port.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one item per handshake: a received byte, a
//   millisecond tick or a link-safety check. rsp_chan returns exactly one
//   result item per input item, in order, holding the latched throttle,
//   roll, pitch, yaw and armed byte plus the packet_accepted, checksum_bad
//   and link_safe flags for that item.
//   An item passes from the input register through the engine into the
//   result register, which loads only when it is free or being taken.
//   Throughput is one item per cycle while rsp_chan does not stall: the input
//   register hands its item to the engine and result register in the same
//   edge that frees it.
//   When rsp_chan stalls, the result register holds, the input register
//   fills, and req_chan.ready drops until the receiver takes the result.
//   csr_wr_en writes register csr_index (0 start marker, 1 timeout in ms,
//   2 failsafe throttle) with csr_wr_data; write only while idle.
//   Synchronous reset restores the register defaults, empties both
//   registers and sets throttle to the default floor, axes and armed to 0.
// ----------------------------------------------------------------------------
module rc_command_packet_deframer_core (
   input  logic                            clock,
   input  logic                            reset,
   rcd_req_if.sink                         req_chan,
   rcd_rsp_if.source                       rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [rcd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rcd_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import rcd_pkg::*;

   rcd_cfg_type    cfg;
   rcd_result_type result;
   rcd_result_type out_data_ff;
   logic           in_valid_ff;
   logic [1:0]     in_opcode_ff;
   logic [7:0]     in_byte_ff;
   logic           out_valid_ff;
   logic           advance;
   logic           in_take;

   rcd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   rcd_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .opcode  (in_opcode_ff),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // Move the held item into the result register when that is free
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign in_take        = req_chan.valid && req_chan.ready;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_opcode_ff <= req_chan.opcode;
         in_byte_ff   <= req_chan.rx_byte;
      end
   end

   // Result register: hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.throttle        = out_data_ff.throttle;
   assign rsp_chan.roll            = out_data_ff.roll;
   assign rsp_chan.pitch           = out_data_ff.pitch;
   assign rsp_chan.yaw             = out_data_ff.yaw;
   assign rsp_chan.armed           = out_data_ff.armed;
   assign rsp_chan.packet_accepted = out_data_ff.packet_accepted;
   assign rsp_chan.checksum_bad    = out_data_ff.checksum_bad;
   assign rsp_chan.link_safe       = out_data_ff.link_safe;

endmodule

// ===== sim/tb_rc_command_packet_deframer_core.sv =====
// ----------------------------------------------------------------------------
// tb_rc_command_packet_deframer_core: self-checking bench of the deframer
// Drives byte, tick and safety-check items through the valid/ready request
// channel, predicts every result item from a local model of the framer,
// latched commands and link timer, and compares each result field by
// field. Several register settings are visited, both sides idle at random,
// and the receiver stalls once for a long stretch to back-pressure the core.
// ----------------------------------------------------------------------------
module tb_rc_command_packet_deframer_core;
   import rcd_pkg::*;

   // Opcode and register index that the core must ignore
   localparam logic [1:0]             OP_SPARE  = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] rx_byte;
   } deframer_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = CSR_START_MARKER;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;

   logic       req_valid   = 1'b0;
   logic [1:0] req_opcode  = OP_RX_BYTE;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_ready   = 1'b0;

   rcd_req_if req_if ();
   rcd_rsp_if rsp_if ();

   assign req_if.valid   = req_valid;
   assign req_if.opcode  = req_opcode;
   assign req_if.rx_byte = req_rx_byte;
   assign rsp_if.ready   = rsp_ready;

   rc_command_packet_deframer_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if.sink),
      .rsp_chan    (rsp_if.source),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the registers and of the framer state
   rcd_cfg_type        cfg_shadow = '{START_MARKER_RST, TIMEOUT_MS_RST, THROTTLE_FLOOR_RST};
   logic               in_frame     = 1'b0;
   int unsigned        frame_fill   = 0;
   logic [7:0]         frame_buf [FRAME_BYTES];
   logic [31:0]        ms_now       = '0;
   logic [31:0]        ms_last_good = '0;
   logic [15:0]        lat_throttle = THROTTLE_FLOOR_RST;
   logic signed [15:0] lat_roll     = '0;
   logic signed [15:0] lat_pitch    = '0;
   logic signed [15:0] lat_yaw      = '0;
   logic [7:0]         lat_armed    = '0;

   deframer_item_type pending_items [$];
   rcd_result_type    expected_results [$];
   deframer_item_type offered;

   int unsigned items_accepted  = 0;
   int unsigned results_checked = 0;
   int unsigned frames_good     = 0;
   int unsigned frames_bad      = 0;
   int unsigned failsafe_trips  = 0;
   int unsigned settings_seen   = 1;
   int unsigned fail_count      = 0;

   bit steady_flow    = 1'b0;
   bit pressure_armed = 1'b0;
   bit rsp_hold       = 1'b0;

   // Advance the framer, tick counter and latched commands by one item
   function automatic rcd_result_type predict_deframer(input deframer_item_type it);
      rcd_result_type r;
      logic [7:0]     sum;
      logic [31:0]    elapsed;
      int             i;
      r = '0;
      case (it.opcode)
         OP_RX_BYTE: begin
            if (!in_frame) begin
               if (it.rx_byte == cfg_shadow.start_marker) begin
                  in_frame   = 1'b1;
                  frame_fill = 0;
               end
            end else begin
               frame_buf[frame_fill] = it.rx_byte;
               frame_fill++;
               if (frame_fill == FRAME_BYTES) begin
                  in_frame   = 1'b0;
                  frame_fill = 0;
                  sum = '0;
                  for (i = 0; i < FRAME_BYTES - 1; i++) sum += frame_buf[i];
                  if (sum == frame_buf[FRAME_BYTES-1]) begin
                     lat_throttle = {frame_buf[0], frame_buf[1]};
                     lat_roll     = {frame_buf[2], frame_buf[3]};
                     lat_pitch    = {frame_buf[4], frame_buf[5]};
                     lat_yaw      = {frame_buf[6], frame_buf[7]};
                     lat_armed    = frame_buf[8];
                     ms_last_good = ms_now;
                     r.packet_accepted = 1'b1;
                  end else begin
                     r.checksum_bad = 1'b1;
                  end
               end
            end
         end
         OP_TICK: begin
            ms_now = ms_now + 32'd1;
         end
         OP_CHECK: begin
            elapsed = ms_now - ms_last_good;
            if (elapsed > 32'(cfg_shadow.timeout_ms)) begin
               lat_throttle = cfg_shadow.throttle_floor;
               lat_armed    = '0;
            end else begin
               r.link_safe = 1'b1;
            end
         end
         default: begin
         end
      endcase
      r.throttle = lat_throttle;
      r.roll     = lat_roll;
      r.pitch    = lat_pitch;
      r.yaw      = lat_yaw;
      r.armed    = lat_armed;
      return r;
   endfunction

   function automatic void queue_item(input logic [1:0] op, input logic [7:0] b);
      pending_items.push_back('{op, b});
   endfunction

   // Queue a start byte, nine payload bytes and a checksum, optionally spoilt
   task automatic queue_frame(input logic [7:0] body [FRAME_BYTES-1], input bit corrupt);
      logic [7:0] sum;
      sum = '0;
      queue_item(OP_RX_BYTE, cfg_shadow.start_marker);
      foreach (body[i]) begin
         sum += body[i];
         queue_item(OP_RX_BYTE, body[i]);
      end
      queue_item(OP_RX_BYTE, corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
   endtask

   // Mostly frames, some spoilt; the rest cut frames, ticks, checks and noise
   task automatic queue_random_traffic(input int unsigned n_target);
      logic [7:0]  body [FRAME_BYTES-1];
      int unsigned queued;
      int unsigned pick;
      int unsigned k;
      queued = 0;
      while (queued < n_target) begin
         pick = $urandom_range(99);
         foreach (body[i]) body[i] = 8'($urandom);
         if (pick < 60) begin
            queue_frame(body, pick >= 50);
            queued += FRAME_BYTES + 1;
         end else if (pick < 65) begin
            // truncated frame: the following items are swallowed as payload
            k = $urandom_range(1, FRAME_BYTES - 2);
            queue_item(OP_RX_BYTE, cfg_shadow.start_marker);
            repeat (k) queue_item(OP_RX_BYTE, 8'($urandom));
            queued += k + 1;
         end else if (pick < 77) begin
            k = $urandom_range(1, 6);
            repeat (k) queue_item(OP_TICK, 8'($urandom));
            queued += k;
         end else if (pick < 87) begin
            queue_item(OP_CHECK, 8'($urandom));
            queued++;
         end else if (pick < 95) begin
            queue_item(OP_RX_BYTE, 8'($urandom));
            queued++;
         end else begin
            queue_item(OP_SPARE, 8'($urandom));
            queued++;
         end
      end
   endtask

   // Wait until every item has gone through and every result has been checked
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || expected_results.size() != 0 || req_valid);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      case (idx)
         CSR_START_MARKER:   cfg_shadow.start_marker   = data[7:0];
         CSR_TIMEOUT_MS:     cfg_shadow.timeout_ms     = data;
         CSR_THROTTLE_FLOOR: cfg_shadow.throttle_floor = data;
         default: begin
         end
      endcase
   endtask

   // Offer items from the pending queue, predicting each one as it is taken
   always @(posedge clock) begin : req_driver
      rcd_result_type predicted;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_if.ready) begin
            predicted = predict_deframer(offered);
            expected_results.push_back(predicted);
            items_accepted++;
            if (predicted.packet_accepted) frames_good++;
            if (predicted.checksum_bad) frames_bad++;
            if (offered.opcode == OP_CHECK && !predicted.link_safe) failsafe_trips++;
         end
         if (!req_valid || req_if.ready) begin
            if (pending_items.size() != 0 && (steady_flow || $urandom_range(99) >= 31)) begin
               offered = pending_items.pop_front();
               req_valid   <= 1'b1;
               req_opcode  <= offered.opcode;
               req_rx_byte <= offered.rx_byte;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Check each result item against the oldest prediction
   always @(posedge clock) begin : rsp_monitor
      rcd_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result item: thr=%h roll=%h pitch=%h yaw=%h arm=%h",
                           rsp_if.throttle, rsp_if.roll, rsp_if.pitch, rsp_if.yaw,
                           rsp_if.armed);
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               if (rsp_if.throttle !== want.throttle || rsp_if.roll !== want.roll ||
                   rsp_if.pitch !== want.pitch || rsp_if.yaw !== want.yaw ||
                   rsp_if.armed !== want.armed ||
                   rsp_if.packet_accepted !== want.packet_accepted ||
                   rsp_if.checksum_bad !== want.checksum_bad ||
                   rsp_if.link_safe !== want.link_safe) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("mismatch on result %0d, expected then actual:",
                              results_checked);
                     $display("  thr=%h roll=%h pitch=%h yaw=%h arm=%h acc=%b bad=%b safe=%b",
                              want.throttle, want.roll, want.pitch, want.yaw,
                              want.armed, want.packet_accepted, want.checksum_bad,
                              want.link_safe);
                     $display("  thr=%h roll=%h pitch=%h yaw=%h arm=%h acc=%b bad=%b safe=%b",
                              rsp_if.throttle, rsp_if.roll, rsp_if.pitch, rsp_if.yaw,
                              rsp_if.armed, rsp_if.packet_accepted, rsp_if.checksum_bad,
                              rsp_if.link_safe);
                  end
               end
            end
         end
         rsp_ready <= !rsp_hold && (steady_flow || $urandom_range(99) >= 31);
      end
   end

   // Hold off the receiver for a long stretch while items keep coming
   initial begin : rsp_backpressure
      int unsigned mark;
      wait (pressure_armed);
      mark = items_accepted + 60;
      while (items_accepted < mark) @(negedge clock);
      rsp_hold = 1'b1;
      repeat (300) @(negedge clock);
      rsp_hold = 1'b0;
   end

   initial begin : run_limit
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      logic [7:0]  body [FRAME_BYTES-1];
      int unsigned spin;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: check at reset, spare opcode, noise, extreme frame, tick, check, bad frame
      queue_item(OP_CHECK, 8'h00);
      queue_item(OP_SPARE, 8'hFF);
      queue_item(OP_RX_BYTE, 8'h55);
      body = '{8'hFF, 8'hFF, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'h00, 8'h01, 8'hFF};
      queue_frame(body, 1'b0);
      queue_item(OP_TICK, 8'hFF);
      queue_item(OP_CHECK, 8'hFF);
      // start byte inside a frame is taken as payload
      body = '{8'h00, 8'h00, 8'hAA, 8'h55, 8'h00, 8'h00, 8'hAA, 8'h55, 8'h00};
      queue_frame(body, 1'b1);
      queue_random_traffic(200);
      wait_drained();

      // Zero marker (upper data bits set), zero timeout, top floor
      write_reg(CSR_START_MARKER, 16'hFF00);
      write_reg(CSR_TIMEOUT_MS, 16'h0000);
      write_reg(CSR_THROTTLE_FLOOR, 16'hFFFF);
      settings_seen++;
      @(negedge clock);
      queue_random_traffic(240);
      wait_drained();

      // Top marker and timeout, zero floor, no idling on either side
      write_reg(CSR_START_MARKER, 16'h00FF);
      write_reg(CSR_TIMEOUT_MS, 16'hFFFF);
      write_reg(CSR_THROTTLE_FLOOR, 16'h0000);
      settings_seen++;
      @(negedge clock);
      steady_flow = 1'b1;
      queue_random_traffic(240);
      wait_drained();
      steady_flow = 1'b0;

      // Random setting, spare index ignored, receiver stall part-way through
      write_reg(CSR_START_MARKER, 16'($urandom));
      write_reg(CSR_TIMEOUT_MS, 16'($urandom_range(3, 40)));
      write_reg(CSR_THROTTLE_FLOOR, 16'($urandom));
      write_reg(CSR_SPARE, 16'($urandom));
      settings_seen++;
      @(negedge clock);
      queue_random_traffic(240);
      pressure_armed = 1'b1;
      wait_drained();

      // Timeout above one byte: elapsed equal to it is safe, one more is not
      write_reg(CSR_START_MARKER, 16'h0055);
      write_reg(CSR_TIMEOUT_MS, 16'h0100);
      write_reg(CSR_THROTTLE_FLOOR, 16'h8001);
      settings_seen++;
      @(negedge clock);
      // flush any frame left open by earlier traffic
      repeat (FRAME_BYTES) queue_item(OP_RX_BYTE, cfg_shadow.start_marker ^ 8'h01);
      foreach (body[i]) body[i] = 8'($urandom);
      queue_frame(body, 1'b0);
      repeat (256) queue_item(OP_TICK, 8'($urandom));
      queue_item(OP_CHECK, 8'($urandom));
      queue_item(OP_TICK, 8'($urandom));
      queue_item(OP_CHECK, 8'($urandom));
      queue_random_traffic(150);

      // Let the last items through, then wait out the remaining results
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid);
      for (spin = 0; spin < 1000 && expected_results.size() != 0; spin++) @(negedge clock);
      repeat (4) @(negedge clock);
      if (expected_results.size() != 0) begin
         $display("%0d result items never arrived", expected_results.size());
         fail_count += expected_results.size();
      end

      $display("covered %0d items over %0d register settings, %0d results checked",
               items_accepted, settings_seen, results_checked);
      $display("%0d good frames, %0d bad checksums, %0d failsafe trips, %0d failures",
               frames_good, frames_bad, failsafe_trips, fail_count);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/rcd_pkg.sv
rtl/rcd_req_if.sv
rtl/rcd_rsp_if.sv
rtl/rcd_csr.sv
rtl/rcd_engine.sv
rtl/rc_command_packet_deframer_core.sv
sim/tb_rc_command_packet_deframer_core.sv
